// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on the block clock, off during reset
`define MLET_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication checked on the block clock, off during reset
`define MLET_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/mlet_pkg.sv
`default_nettype none

package mlet_pkg;

	// domain and tree geometry
	localparam int X_BITS     = 16;
	localparam int NODE_BITS  = X_BITS + 1;
	localparam int NODE_COUNT = 1 << NODE_BITS;
	localparam int HALF       = 1 << (X_BITS - 1);
	localparam int LVL_W      = $clog2(X_BITS + 1);

	// field widths
	localparam int COEF_W = 32;
	localparam int LINE_W = 2 * COEF_W;
	localparam int QX_W   = 16;
	localparam int BEST_W = 49;

	// arithmetic widths
	localparam int DIFF_W  = COEF_W + 1;
	localparam int PDIFF_W = DIFF_W + X_BITS;
	localparam int DSUM_W  = PDIFF_W + 1;
	localparam int PROD_W  = COEF_W + X_BITS;
	localparam int EVAL_W  = PROD_W + 1;

	// request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// memory word layout: slope high, intercept low
	typedef struct packed {
		logic signed [COEF_W-1:0] slp;
		logic signed [COEF_W-1:0] icpt;
	} line_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_I_DIFF,
		ST_I_MUL,
		ST_I_CMP,
		ST_Q_RUN,
		ST_Q_WAIT
	} state_t;

	// saturate a signed point to the domain and shift it to an offset
	function automatic logic [X_BITS-1:0] to_offset(input logic signed [QX_W-1:0] qx);
		int v;
		v = int'(qx);
		if (v < -HALF) v = -HALF;
		if (v > HALF - 1) v = HALF - 1;
		return X_BITS'(v + HALF);
	endfunction

	// offset back to signed point: flip the top bit
	function automatic logic signed [X_BITS-1:0] to_point(input logic [X_BITS-1:0] u);
		return $signed({~u[X_BITS-1], u[X_BITS-2:0]});
	endfunction

endpackage

`default_nettype wire

// File: src/mlet_if.sv
`default_nettype none

// request channel
interface mlet_req_if import mlet_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic signed [COEF_W-1:0] line_intercept;
	logic signed [COEF_W-1:0] line_slope;
	logic signed [QX_W-1:0]   query_x;

	modport source (output valid, req_type, line_intercept, line_slope, query_x,
		input ready);
	modport sink (input valid, req_type, line_intercept, line_slope, query_x,
		output ready);
endinterface

// result channel
interface mlet_res_if import mlet_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [BEST_W-1:0] best_value;

	modport source (output valid, best_value, input ready);
	modport sink (input valid, best_value, output ready);
endinterface

`default_nettype wire

// File: src/mlet_ram.sv
`default_nettype none

module mlet_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: src/max_line_envelope_tree_core.sv
// Li Chao tree, max envelope, node lines kept in one dual-port RAM (registered read).
// Insert: accepted in the idle state, then per tree level visited: read, multiply,
//   compare and write back; it produces no beat.
// Query: one path read per cycle, pipelined; no new request until the result loads.
// Reset: async, active low; then a clearing pass zeroes every node while the
//   request channel is held not ready.
`default_nettype none

module max_line_envelope_tree_core import mlet_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	mlet_req_if.sink  req,
	mlet_res_if.source res
);

	`include "assert_macros.svh"

	state_t state_q, state_d;

	// ram port
	logic                 ram_we;
	logic [NODE_BITS-1:0] ram_waddr;
	logic [LINE_W-1:0]    ram_wdata;
	logic [NODE_BITS-1:0] ram_raddr;
	logic [LINE_W-1:0]    ram_rdata;
	line_t                rline;

	// insert walk
	line_t                      cur_q, node_q;
	logic [NODE_BITS-1:0]       p_q, clr_q;
	logic [X_BITS-1:0]          s_q, e_q, m_q;
	logic signed [DIFF_W-1:0]   di_q, ds_q;
	logic signed [PDIFF_W-1:0]  ps_q, pe_q, pm_q;
	logic signed [DSUM_W-1:0]   d_s, d_e, d_m;
	logic                       ins_swap, ins_dom, ins_mid;
	line_t                      line_a_cur, line_a_nd, ins_wline, ins_next_cur;
	logic [NODE_BITS-1:0]       ins_child;

	// query walk
	logic [X_BITS-1:0]          u_q;
	logic [LVL_W-1:0]           lvl_q;
	logic [NODE_BITS-1:0]       q_addr;
	logic                       q_rd_s1, q_last_s1, q_vld_s2, q_last_s2, q_done_q;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [COEF_W-1:0]   icpt_s2;
	logic signed [EVAL_W-1:0]   q_val, best_q;

	// output register
	logic                       res_vld_q;
	logic signed [BEST_W-1:0]   res_val_q;
	logic                       load_out;
	logic                       accept;

	mlet_ram #(
		.WIDTH(LINE_W),
		.DEPTH(NODE_COUNT)
	) u_node_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rline  = line_t'(ram_rdata);
	assign accept = req.valid && req.ready;

	// insert decision from the three difference signs
	always_comb begin
		d_s = DSUM_W'(di_q) + DSUM_W'(ps_q);
		d_e = DSUM_W'(di_q) + DSUM_W'(pe_q);
		d_m = DSUM_W'(di_q) + DSUM_W'(pm_q);
		ins_swap = d_s > 0;
		ins_dom  = ins_swap ? (d_e >= 0) : (d_e <= 0);
		ins_mid  = ins_swap ? (d_m < 0) : (d_m > 0);
		line_a_cur   = ins_swap ? node_q : cur_q;
		line_a_nd    = ins_swap ? cur_q : node_q;
		ins_wline    = (!ins_dom && ins_mid) ? line_a_cur : line_a_nd;
		ins_next_cur = ins_mid ? line_a_nd : line_a_cur;
		ins_child    = {p_q[NODE_BITS-2:0], ~ins_mid};
	end

	// query path node at the current level
	assign q_addr = NODE_BITS'({1'b1, u_q} >> (LVL_W'(X_BITS) - lvl_q));
	assign q_val  = EVAL_W'(icpt_s2) + EVAL_W'(prod_s2);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == {NODE_BITS{1'b1}}) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.req_type == REQ_QUERY) ? ST_Q_RUN : ST_I_DIFF;
				end
			end
			ST_I_DIFF: state_d = ST_I_MUL;
			ST_I_MUL:  state_d = ST_I_CMP;
			ST_I_CMP:  state_d = ins_dom ? ST_IDLE : ST_I_DIFF;
			ST_Q_RUN: begin
				if (lvl_q == LVL_W'(X_BITS)) state_d = ST_Q_WAIT;
			end
			ST_Q_WAIT: begin
				if (q_done_q && (!res_vld_q || res.ready)) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs: ram port, ready, result load
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = p_q;
		ram_wdata = ins_wline;
		ram_raddr = p_q;
		req.ready = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				ram_raddr = NODE_BITS'(1);
			end
			ST_I_CMP: begin
				ram_we    = 1'b1;
				ram_raddr = ins_child;
			end
			ST_Q_RUN: begin
				ram_raddr = q_addr;
			end
			ST_Q_WAIT: begin
				load_out = q_done_q && (!res_vld_q || res.ready);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			q_rd_s1   <= 1'b0;
			q_last_s1 <= 1'b0;
			q_vld_s2  <= 1'b0;
			q_last_s2 <= 1'b0;
			q_done_q  <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + NODE_BITS'(1);
			q_rd_s1   <= (state_q == ST_Q_RUN);
			q_last_s1 <= (state_q == ST_Q_RUN) && (lvl_q == LVL_W'(X_BITS));
			q_vld_s2  <= q_rd_s1;
			q_last_s2 <= q_last_s1;
			if (accept) begin
				q_done_q <= 1'b0;
			end else if (q_vld_s2 && q_last_s2) begin
				q_done_q <= 1'b1;
			end
			if (load_out) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// insert walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_q.icpt <= req.line_intercept;
				cur_q.slp  <= req.line_slope;
				p_q        <= NODE_BITS'(1);
				s_q        <= '0;
				e_q        <= '1;
			end
			ST_I_DIFF: begin
				node_q <= rline;
				di_q   <= DIFF_W'(cur_q.icpt) - DIFF_W'(rline.icpt);
				ds_q   <= DIFF_W'(cur_q.slp) - DIFF_W'(rline.slp);
				m_q    <= X_BITS'(({1'b0, s_q} + {1'b0, e_q}) >> 1);
			end
			ST_I_MUL: begin
				ps_q <= ds_q * to_point(s_q);
				pe_q <= ds_q * to_point(e_q);
				pm_q <= ds_q * to_point(m_q);
			end
			ST_I_CMP: begin
				if (!ins_dom) begin
					cur_q <= ins_next_cur;
					p_q   <= ins_child;
					if (ins_mid) begin
						e_q <= m_q;
					end else begin
						s_q <= m_q + X_BITS'(1);
					end
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	// query walk datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			u_q    <= to_offset(req.query_x);
			lvl_q  <= '0;
			best_q <= {1'b1, {(EVAL_W-1){1'b0}}};
		end else begin
			if (state_q == ST_Q_RUN) lvl_q <= lvl_q + LVL_W'(1);
			if (q_vld_s2 && (q_val > best_q)) best_q <= q_val;
		end
		// evaluate each path line at the query point
		if (q_rd_s1) begin
			prod_s2 <= rline.slp * to_point(u_q);
			icpt_s2 <= rline.icpt;
		end
		if (load_out) res_val_q <= BEST_W'(best_q);
	end

	assign res.valid      = res_vld_q;
	assign res.best_value = res_val_q;

	// checks
	`MLET_ASSERT_IMP(a_wr_rd_apart, state_q == ST_I_CMP && !ins_dom, ram_waddr != ram_raddr, "insert writes the node it reads")
	`MLET_ASSERT_IMP(a_path_level, state_q == ST_Q_RUN, (ram_raddr >> lvl_q) == NODE_BITS'(1), "query read off its level")
	`MLET_ASSERT_IMP(a_query_no_write, state_q == ST_Q_RUN || state_q == ST_Q_WAIT, !ram_we, "ram write during query")
	`MLET_ASSERT_IMP(a_res_from_query, $rose(res_vld_q), $past(state_q == ST_Q_WAIT), "result beat without query")
	`MLET_ASSERT_IMP(a_clear_blocks, state_q == ST_CLEAR, !req.ready && !res_vld_q, "activity during clearing pass")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none

module tb import mlet_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STRUCT_ITEMS = 1300;
	localparam int WILD_ITEMS   = 250;
	localparam int TAIL_ITEMS   = 120;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 3 * (X_BITS + 1) + X_BITS + 10;
	localparam int MAX_REPORTS  = 40;

	typedef struct {
		logic                     kind;
		logic signed [COEF_W-1:0] icpt;
		logic signed [COEF_W-1:0] slp;
		logic signed [QX_W-1:0]   qx;
	} req_item_t;

	logic clk;
	logic arst_n;

	mlet_req_if req_bus ();
	mlet_res_if res_bus ();

	max_line_envelope_tree_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.res(res_bus)
	);

	req_item_t                pending[$];
	logic signed [BEST_W-1:0] best_due[$];
	line_t                    node_line_mem[int];

	logic req_taken;
	int   send_idle, send_idle_pct;
	int   take_idle, take_idle_pct;
	int   total_items, items_taken;
	int   inserts_seen, queries_seen, results_checked, fails;
	int   cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------- envelope predictor ----------------

	function automatic line_t node_line(input int node);
		if (node_line_mem.exists(node))
			return node_line_mem[node];
		return '0;
	endfunction

	// line value at offset point u
	function automatic longint line_at(input line_t ln, input longint u);
		longint x;
		x = u - HALF;
		return longint'(ln.icpt) + longint'(ln.slp) * x;
	endfunction

	// walk down keeping the larger line at each node's left end
	function automatic void envelope_insert(input line_t ln);
		line_t  cur, held, swp;
		int     node;
		longint lo, hi, mid;
		bit     walking;
		cur = ln;
		node = 1;
		lo = 0;
		hi = (longint'(1) << X_BITS) - 1;
		walking = 1'b1;
		while (walking) begin
			held = node_line(node);
			if (line_at(cur, lo) > line_at(held, lo)) begin
				swp = cur; cur = held; held = swp;
			end
			if (line_at(cur, hi) <= line_at(held, hi)) begin
				// dominated over the whole node, ties at the right end included
				node_line_mem[node] = held;
				walking = 1'b0;
			end else begin
				mid = (lo + hi) >> 1;
				if (line_at(cur, mid) > line_at(held, mid)) begin
					swp = cur; cur = held; held = swp;
					node_line_mem[node] = held;
					node = 2 * node;
					hi = mid;
				end else begin
					node_line_mem[node] = held;
					node = 2 * node + 1;
					lo = mid + 1;
				end
			end
		end
	endfunction

	// best line value along the root-to-leaf path of a point
	function automatic logic signed [BEST_W-1:0] envelope_peak(input logic signed [QX_W-1:0] qx);
		longint x, u, lo, hi, mid, best, v;
		int     node;
		x = longint'(qx);
		if (x < -HALF) x = -HALF;
		if (x > HALF - 1) x = HALF - 1;
		u = x + HALF;
		node = 1;
		lo = 0;
		hi = (longint'(1) << X_BITS) - 1;
		best = line_at(node_line(node), u);
		while (lo < hi) begin
			mid = (lo + hi) >> 1;
			if (u <= mid) begin
				node = 2 * node;
				hi = mid;
			end else begin
				node = 2 * node + 1;
				lo = mid + 1;
			end
			v = line_at(node_line(node), u);
			if (v > best) best = v;
		end
		return BEST_W'(best);
	endfunction

	// ---------------- stimulus helpers ----------------

	// unused fields carry junk on purpose
	task automatic add_insert(input logic signed [COEF_W-1:0] icpt,
			input logic signed [COEF_W-1:0] slp);
		req_item_t it;
		it.kind = REQ_INSERT;
		it.icpt = icpt;
		it.slp = slp;
		it.qx = QX_W'($urandom);
		pending = {pending, it};
	endtask

	task automatic add_query(input logic signed [QX_W-1:0] qx);
		req_item_t it;
		it.kind = REQ_QUERY;
		it.icpt = $urandom;
		it.slp = $urandom;
		it.qx = qx;
		pending = {pending, it};
	endtask

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 50;
		endcase
	endfunction

	// ---------------- request driver ----------------

	always @(negedge clk) begin
		req_item_t nxt;
		logic      drive_valid;
		drive_valid = req_bus.valid;
		nxt.kind = req_bus.req_type;
		nxt.icpt = req_bus.line_intercept;
		nxt.slp = req_bus.line_slope;
		nxt.qx = req_bus.query_x;
		if (arst_n && (!req_bus.valid || req_taken)) begin
			drive_valid = 1'b0;
			if (send_idle > 0)
				send_idle--;
			else if (pending.size() != 0) begin
				if (pending.size() >= TAIL_ITEMS && $urandom_range(0, 99) < send_idle_pct)
					send_idle = $urandom_range(0, 8);
				else begin
					nxt = pending.pop_front();
					drive_valid = 1'b1;
				end
			end
			if ($urandom_range(0, 63) == 0) send_idle_pct = pick_pct();
		end
		req_bus.valid <= drive_valid;
		req_bus.req_type <= nxt.kind;
		req_bus.line_intercept <= nxt.icpt;
		req_bus.line_slope <= nxt.slp;
		req_bus.query_x <= nxt.qx;
	end

	// ---------------- result ready driver ----------------

	always @(negedge clk) begin
		logic take;
		take = 1'b0;
		if (arst_n) begin
			if (take_idle > 0)
				take_idle--;
			else if (pending.size() >= TAIL_ITEMS && $urandom_range(0, 99) < take_idle_pct)
				take_idle = $urandom_range(0, 8);
			else
				take = 1'b1;
			if ($urandom_range(0, 63) == 0) take_idle_pct = pick_pct();
		end
		res_bus.ready <= take;
	end

	// ---------------- monitor and checker ----------------

	always @(posedge clk) begin
		line_t                    ln;
		logic signed [BEST_W-1:0] want;
		if (!arst_n)
			req_taken <= 1'b0;
		else begin
			req_taken <= req_bus.valid && req_bus.ready;
			// request beat: update the envelope or queue the expected peak
			if (req_bus.valid && req_bus.ready) begin
				items_taken++;
				if (req_bus.req_type == REQ_INSERT) begin
					inserts_seen++;
					ln.icpt = req_bus.line_intercept;
					ln.slp = req_bus.line_slope;
					envelope_insert(ln);
				end else begin
					queries_seen++;
					best_due = {best_due, envelope_peak(req_bus.query_x)};
				end
			end
			// result beat
			if (res_bus.valid && res_bus.ready) begin
				if (best_due.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("%0t: result beat with nothing pending, best_value %0d",
							$time, res_bus.best_value);
				end else begin
					want = best_due.pop_front();
					results_checked++;
					if (res_bus.best_value !== want) begin
						fails++;
						if (fails <= MAX_REPORTS)
							$display("%0t: best_value mismatch, expected %0d, actual %0d",
								$time, want, res_bus.best_value);
					end
				end
			end
		end
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d of %0d requests taken, %0d results outstanding",
				$time, items_taken, total_items, best_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------- stimulus and end of run ----------------

	initial begin
		int     n, style, x0, sl, last_x0;
		longint ic;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_INSERT;
		req_bus.line_intercept = '0;
		req_bus.line_slope = '0;
		req_bus.query_x = '0;
		res_bus.ready = 1'b0;
		send_idle = 0;
		take_idle = 0;
		send_idle_pct = 15;
		take_idle_pct = 15;
		items_taken = 0;
		inserts_seen = 0;
		queries_seen = 0;
		results_checked = 0;
		fails = 0;
		cycles = 0;
		last_x0 = 0;

		// fresh tree: every point sees the zero line
		add_query(-16'sd32768);
		add_query(16'sd32767);
		add_query(16'sd0);
		// small line, then the same line again (tie everywhere)
		add_insert(32'sd5, 32'sd3);
		add_insert(32'sd5, 32'sd3);
		// equal to the stored line at the right end only, stays at the root
		add_insert(-32'sd32762, 32'sd4);
		// below the zero line everywhere
		add_insert(-32'sd1, 32'sd0);
		// crosses the stored line near x = 12, walks deep
		add_insert(32'sd100, -32'sd5);
		add_query(-16'sd32768);
		add_query(-16'sd1);
		add_query(16'sd11);
		add_query(16'sd12);
		add_query(16'sd32767);
		add_query(16'sd12345);

		// structured lines crossing near random points with a rising base
		for (n = 0; n < STRUCT_ITEMS; n++) begin
			if ($urandom_range(0, 99) < 45) begin
				style = $urandom_range(0, 9);
				if (style < 7) begin
					x0 = int'($urandom_range(0, 65535)) - 32768;
					sl = int'($urandom_range(0, 32766)) - 16383;
					ic = longint'(n) * 1048576 - longint'(sl) * x0
						+ (int'($urandom_range(0, 2000)) - 1000);
					last_x0 = x0;
					add_insert(COEF_W'(ic), COEF_W'(sl));
				end else
					add_insert(COEF_W'(int'($urandom_range(0, 2000)) - 1000),
						COEF_W'(int'($urandom_range(0, 128)) - 64));
			end else begin
				style = $urandom_range(0, 19);
				case (style)
					0: add_query(-16'sd32768);
					1: add_query(16'sd32767);
					2: add_query(-16'sd1);
					3, 4, 5, 6, 7, 8: add_query(QX_W'(last_x0 + int'($urandom_range(0, 6)) - 3));
					default: add_query(QX_W'($urandom));
				endcase
			end
		end

		// full-range lines and points
		for (n = 0; n < WILD_ITEMS; n++) begin
			if ($urandom_range(0, 99) < 40)
				add_insert($urandom, $urandom);
			else
				add_query(QX_W'($urandom));
		end

		// extreme coefficients
		add_insert(32'sh7fffffff, 32'sd0);
		add_insert(32'sh80000000, 32'sh7fffffff);
		add_insert(32'sd0, 32'sh80000000);
		add_insert(32'sh80000000, 32'sh80000000);
		add_insert(32'sh7fffffff, 32'sh7fffffff);
		add_query(-16'sd32768);
		add_query(16'sd32767);
		add_query(-16'sd1);
		add_query(16'sd0);

		total_items = pending.size();

		// reset, released on a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every request taken, every result back, then let the block settle
		while (items_taken < total_items || best_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d line inserts and %0d point queries, %0d peak values compared",
			inserts_seen, queries_seen, results_checked);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+src
src/mlet_pkg.sv
src/mlet_if.sv
src/mlet_ram.sv
src/max_line_envelope_tree_core.sv
tb/sv/tb.sv
